// ===== sv/msgd_pkg.sv =====
// Shared types and constants of the momentum SGD update block.
`timescale 1ns / 1ps

package msgd_pkg;

	// Field widths fixed by the item format.
	localparam int IDX_W    = 12;
	localparam int DATA_W   = 32;
	localparam int COEFF_W  = 16;
	localparam int CFG_IDX_W = 2;

	// Number of distinct element indexes an item can carry.
	localparam int IDX_SPAN = 2 ** IDX_W;

	typedef logic        [IDX_W-1:0]     elem_idx_t;
	typedef logic signed [DATA_W-1:0]    q16_t;
	typedef logic        [COEFF_W-1:0]   coeff_t;
	typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOMENTUM  = 2'd0,
		REG_STEP_RATE = 2'd1
	} cfg_reg_t;

	// Register values after reset.
	localparam coeff_t MOMENTUM_RESET  = 16'd58982;
	localparam coeff_t STEP_RATE_RESET = 16'd655;

endpackage

// ===== sv/msgd_intf.sv =====
// Handshake channels of the momentum SGD update block: request, result and configuration.
`timescale 1ns / 1ps

interface msgd_req_if import msgd_pkg::*; ();
	logic      valid;
	logic      ready;
	elem_idx_t elem_index;
	q16_t      weight_in;
	q16_t      grad_in;
	logic      fresh;

	modport source (output valid, output elem_index, output weight_in, output grad_in,
		output fresh, input ready);
	modport sink (input valid, input elem_index, input weight_in, input grad_in,
		input fresh, output ready);
endinterface

interface msgd_rsp_if import msgd_pkg::*; ();
	logic valid;
	logic ready;
	q16_t weight_out;
	q16_t velocity_out;
	logic clipped;

	modport source (output valid, output weight_out, output velocity_out, output clipped,
		input ready);
	modport sink (input valid, input weight_out, input velocity_out, input clipped,
		output ready);
endinterface

interface msgd_cfg_if import msgd_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t reg_index;
	coeff_t   wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== sv/momentum_sgd_update.sv =====
// Momentum SGD update: v = mu*v - lr*g kept in a velocity RAM, result w + v, both saturated.
// An accepted item passes s1, s2, s3, s4 and the output register before its result is offered.
// Throughput: one item per cycle while results are taken; an item whose index matches the item
// directly ahead of it, and is not marked fresh, waits in s2 until that item has written back.
// Reset: control clears at once, then a clearing pass zeroes all min(VELOCITY_ENTRIES, 4096)
// entries of the velocity RAM with req.ready low; configuration writes are taken throughout.
`timescale 1ns / 1ps

module momentum_sgd_update import msgd_pkg::*; #(
	parameter int VELOCITY_ENTRIES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	msgd_cfg_if.sink    cfg,
	msgd_req_if.sink    req,
	msgd_rsp_if.source  rsp
);

	// Only the first IDX_SPAN entries can ever be addressed, so the RAM is no deeper than that.
	localparam int DEPTH   = (VELOCITY_ENTRIES < IDX_SPAN) ? VELOCITY_ENTRIES : IDX_SPAN;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam bit IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);

	// Products are 17 x 32 bits; the difference and rounding need one more bit.
	localparam int PROD_W = COEFF_W + 1 + DATA_W;
	localparam int DIFF_W = PROD_W + 1;
	localparam int WIDE_W = DATA_W + 2;
	localparam logic signed [DIFF_W-1:0] ROUND_HALF = DIFF_W'(2 ** (COEFF_W - 1));

	typedef logic [AW-1:0] addr_t;

	// Saturates a value to the signed 32-bit range. The top bit of the result is the clip flag.
	function automatic logic [DATA_W:0] sat_q16(input logic signed [WIDE_W-1:0] x);
		logic hi;
		logic lo;
		hi = (x > $signed(WIDE_W'({1'b0, {(DATA_W-1){1'b1}}})));
		lo = (x < $signed({{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}}));
		if (hi) begin
			return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
		end else if (lo) begin
			return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
		end
		return {1'b0, x[DATA_W-1:0]};
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers. Writes are only expected while the block is
	// idle, so they take effect without any hand-off to the pipeline.
	// ------------------------------------------------------------------
	coeff_t mu_q;
	coeff_t lr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= MOMENTUM_RESET;
			lr_q <= STEP_RATE_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.reg_index))
				REG_MOMENTUM:  mu_q <= cfg.wdata;
				REG_STEP_RATE: lr_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Clearing pass after reset. One entry is zeroed per cycle and no item
	// is taken until the whole RAM is done.
	// ------------------------------------------------------------------
	logic  clr_busy_q;
	addr_t clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipeline:
	//   s1  item registered, RAM index reduced, RAM read issued
	//   s2  old velocity from the RAM or forwarded from s4, both products formed
	//   s3  difference rounded and saturated, new velocity written back
	//   s4  new velocity held for forwarding, weight sum formed into the output register
	// Each stage moves when the one after it is free or moving, save s2 on an index
	// hazard, so a stalled result only blocks the pipeline once every stage is full.
	// ------------------------------------------------------------------
	logic      valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	elem_idx_t raw_s1;
	q16_t      w_s1, g_s1;
	logic      fresh_s1;

	addr_t     idx_s1, idx_s2, idx_s3, idx_s4;
	q16_t      w_s2, g_s2, rd_s2;
	logic      fresh_s2;

	q16_t                      w_s3;
	logic signed [PROD_W-1:0]  mv_s3, lg_s3;

	q16_t w_s4, v_s4;
	logic clip_s4;

	q16_t wout_q, vout_q;
	logic clip_q;

	logic en1, en2, en3, en4, en_out;
	logic adv1, adv2, adv3, adv4;
	logic acc_in;
	logic hazard;

	assign en_out = !out_valid_q || rsp.ready;
	assign adv4   = valid_s4 && en_out;
	assign en4    = !valid_s4 || en_out;
	assign adv3   = valid_s3 && en4;
	assign en3    = !valid_s3 || en4;

	// The item in s3 has not written its velocity yet; a follower on the same
	// entry, unless marked fresh, waits until that item has moved on and then picks the value up from s4.
	assign hazard = valid_s2 && valid_s3 && !fresh_s2 && (idx_s2 == idx_s3);
	assign adv2   = valid_s2 && en3 && !hazard;
	assign en2    = !valid_s2 || adv2;
	assign adv1   = valid_s1 && en2;
	assign en1    = !valid_s1 || en2;

	assign req.ready = en1 && !clr_busy_q;
	assign acc_in    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= acc_in;
			end
			if (en2) begin
				valid_s2 <= adv1;
			end
			if (en3) begin
				valid_s3 <= adv2;
			end
			if (en4) begin
				valid_s4 <= adv3;
			end
			if (en_out) begin
				out_valid_q <= adv4;
			end
		end
	end

	// ---------------- s1: capture and index reduction ----------------
	always_ff @(posedge clk) begin
		if (acc_in) begin
			raw_s1   <= req.elem_index;
			w_s1     <= req.weight_in;
			g_s1     <= req.grad_in;
			fresh_s1 <= req.fresh;
		end
	end

	// The element index wraps modulo the store depth. A power-of-two depth is a
	// plain mask. Any other depth uses an exact reciprocal multiplication for the
	// quotient, taken at capture, and a multiply-subtract for the remainder in s1.
	generate
		if (DEPTH == 1) begin : g_idx_single
			assign idx_s1 = '0;
		end else if (IS_POW2) begin : g_idx_mask
			assign idx_s1 = raw_s1[AW-1:0];
		end else begin : g_idx_recip
			localparam int    RSH   = IDX_W + $clog2(DEPTH);
			localparam int    PW    = IDX_W + RSH;
			localparam longint RECIP = ((longint'(1) << RSH) + DEPTH - 1) / DEPTH;

			logic [PW-1:0]      quot_prod;
			elem_idx_t          quot_s1;
			logic [2*IDX_W-1:0] rem;

			assign quot_prod = PW'(req.elem_index) * PW'(RECIP);

			always_ff @(posedge clk) begin
				if (acc_in) begin
					quot_s1 <= quot_prod[PW-1:RSH];
				end
			end

			assign rem    = (2*IDX_W)'(raw_s1) - (2*IDX_W)'(quot_s1) * (2*IDX_W)'(DEPTH);
			assign idx_s1 = rem[AW-1:0];
		end
	endgenerate

	// ---------------- velocity RAM ----------------
	// Read-before-write: a read and a write of the same entry in one cycle
	// return the old value, which the forwarding from s4 then covers.
	q16_t  vel_mem [DEPTH];
	logic  mem_we;
	addr_t mem_wa;
	q16_t  mem_wd;
	q16_t  v_new;

	assign mem_we = clr_busy_q || adv3;
	assign mem_wa = clr_busy_q ? clr_addr_q : idx_s3;
	assign mem_wd = clr_busy_q ? '0 : v_new;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vel_mem[mem_wa] <= mem_wd;
		end
		if (adv1) begin
			rd_s2 <= vel_mem[idx_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			idx_s2   <= idx_s1;
			w_s2     <= w_s1;
			g_s2     <= g_s1;
			fresh_s2 <= fresh_s1;
		end
	end

	// ---------------- s2: old velocity and products ----------------
	// The item in s4 is the newest one that may have written this entry
	// after the RAM was read, so its velocity takes priority.
	q16_t                     v_old;
	logic                     fwd_s4;
	logic signed [PROD_W-1:0] mv_c, lg_c;

	assign fwd_s4 = valid_s4 && (idx_s4 == idx_s2);
	assign v_old  = fresh_s2 ? '0 : (fwd_s4 ? v_s4 : rd_s2);
	assign mv_c   = $signed({1'b0, mu_q}) * v_old;
	assign lg_c   = $signed({1'b0, lr_q}) * g_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			idx_s3 <= idx_s2;
			w_s3   <= w_s2;
			mv_s3  <= mv_c;
			lg_s3  <= lg_c;
		end
	end

	// ---------------- s3: round, saturate, write back ----------------
	// Adding half a unit and dropping the coefficient fraction bits with an
	// arithmetic shift rounds to nearest with ties towards plus infinity.
	logic signed [DIFF_W-1:0] diff_c;
	logic [DATA_W:0]          v_sat;

	assign diff_c = DIFF_W'(mv_s3) - DIFF_W'(lg_s3) + ROUND_HALF;
	assign v_sat  = sat_q16(WIDE_W'(diff_c >>> COEFF_W));
	assign v_new  = v_sat[DATA_W-1:0];

	always_ff @(posedge clk) begin
		if (adv3) begin
			idx_s4  <= idx_s3;
			w_s4    <= w_s3;
			v_s4    <= v_new;
			clip_s4 <= v_sat[DATA_W];
		end
	end

	// ---------------- s4: weight update into the output register ----------------
	logic signed [WIDE_W-1:0] w_sum;
	logic [DATA_W:0]          w_sat;

	assign w_sum = WIDE_W'(w_s4) + WIDE_W'(v_s4);
	assign w_sat = sat_q16(w_sum);

	always_ff @(posedge clk) begin
		if (adv4) begin
			wout_q <= w_sat[DATA_W-1:0];
			vout_q <= v_s4;
			clip_q <= clip_s4 || w_sat[DATA_W];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.weight_out   = wout_q;
	assign rsp.velocity_out = vout_q;
	assign rsp.clipped      = clip_q;

`ifndef ASSERT_OFF
	// Once the clearing pass has finished it never starts again.
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_busy_q |=> !clr_busy_q)
		else $error("velocity clearing restarted");

	// No item reaches the write-back stage while the RAM is being cleared.
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> !clr_busy_q)
		else $error("item write-back during clearing pass");

	// The reduced index always lies inside the RAM.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (idx_s1 <= AW'(DEPTH - 1)))
		else $error("velocity index out of range");

	// An item never leaves s2 on an entry whose update is still in s3.
	a_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && valid_s3 && !fresh_s2) |-> (idx_s2 != idx_s3))
		else $error("read of a velocity entry still being updated");
`endif

endmodule

// ===== verif/momentum_sgd_update_check.sv =====
// Checker of the momentum SGD update block: predicts each result and compares it.
`timescale 1ns / 1ps

module momentum_sgd_update_check import msgd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	msgd_cfg_if  cfg,
	msgd_req_if  req,
	msgd_rsp_if  rsp,
	output int   mismatches,
	output int   pending,
	output int   results_seen,
	output int   clip_count
);

	localparam int     REPORT_LIMIT = 10;
	localparam longint Q_MAX        = (longint'(1) <<< (DATA_W - 1)) - 1;
	localparam longint Q_MIN        = -(longint'(1) <<< (DATA_W - 1));
	localparam longint ROUND_BIAS   = longint'(1) <<< (COEFF_W - 1);

	typedef struct packed {
		q16_t weight;
		q16_t velocity;
		logic clipped;
	} update_t;

	q16_t    velocity_mem [IDX_SPAN];
	coeff_t  momentum;
	coeff_t  step_rate;
	update_t pending_updates [$];

	// New velocity mu*v - lr*g, rounded to nearest with ties upwards, then the new weight.
	function automatic update_t apply_momentum(input q16_t v_prev, input q16_t w,
			input q16_t g, input coeff_t mu, input coeff_t lr);
		longint  d;
		longint  v;
		longint  s;
		update_t r;
		r.clipped = 1'b0;
		d = longint'(mu) * longint'(v_prev) - longint'(lr) * longint'(g);
		v = (d + ROUND_BIAS) >>> COEFF_W;
		if (v > Q_MAX) begin
			v = Q_MAX;
			r.clipped = 1'b1;
		end else if (v < Q_MIN) begin
			v = Q_MIN;
			r.clipped = 1'b1;
		end
		s = longint'(w) + v;
		if (s > Q_MAX) begin
			s = Q_MAX;
			r.clipped = 1'b1;
		end else if (s < Q_MIN) begin
			s = Q_MIN;
			r.clipped = 1'b1;
		end
		r.velocity = q16_t'(v);
		r.weight   = q16_t'(s);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		update_t got;
		update_t want;
		q16_t    v_prev;
		if (!arst_n) begin
			foreach (velocity_mem[i])
				velocity_mem[i] = '0;
			momentum  = MOMENTUM_RESET;
			step_rate = STEP_RATE_RESET;
			pending_updates.delete();
			pending = 0;
		end else begin
			// Results first: an item accepted at this edge cannot already have its result.
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				got.weight   = rsp.weight_out;
				got.velocity = rsp.velocity_out;
				got.clipped  = rsp.clipped;
				if (pending_updates.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected result w=%0d v=%0d clip=%b", $realtime,
							got.weight, got.velocity, got.clipped);
				end else begin
					want = pending_updates.pop_front();
					if (want.clipped)
						clip_count++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: mismatch w=%0d/%0d v=%0d/%0d clip=%b/%b (exp/got)",
								$realtime, want.weight, got.weight, want.velocity,
								got.velocity, want.clipped, got.clipped);
					end
				end
			end
			if (req.valid && req.ready) begin
				v_prev = req.fresh ? '0 : velocity_mem[req.elem_index];
				want = apply_momentum(v_prev, req.weight_in, req.grad_in, momentum, step_rate);
				velocity_mem[req.elem_index] = want.velocity;
				pending_updates.push_back(want);
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					REG_MOMENTUM:  momentum  = cfg.wdata;
					REG_STEP_RATE: step_rate = cfg.wdata;
					default: ;
				endcase
			end
			pending = pending_updates.size();
		end
	end

endmodule

// ===== verif/momentum_sgd_update_test.sv =====
// Testbench top of the momentum SGD update block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module momentum_sgd_update_test;
	import msgd_pkg::*;

	localparam int       CYCLE_LIMIT   = 200000;
	localparam int       RANDOM_ITEMS  = 950;
	localparam int       SEGMENTS      = 6;
	localparam int       HOLD_AFTER    = 700;
	localparam int       HOLD_CYCLES   = 400;
	localparam int       SETTLE_CYCLES = 16;
	localparam q16_t     Q_MAX         = 32'sh7fff_ffff;
	localparam q16_t     Q_MIN         = 32'sh8000_0000;
	// Register indexes past the end of the list; writes to them must change nothing.
	localparam cfg_idx_t REG_SPARE_A   = 2'd2;
	localparam cfg_idx_t REG_SPARE_B   = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	int   send_idle;
	int   recv_idle;
	int   items_sent = 0;
	int   settings = 0;
	int   mismatches;
	int   pending;
	int   results_seen;
	int   clip_count;

	msgd_cfg_if cfg_ch ();
	msgd_req_if req_ch ();
	msgd_rsp_if rsp_ch ();

	momentum_sgd_update DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	momentum_sgd_update_check update_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_ch),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen),
		.clip_count   (clip_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A hung handshake would otherwise run for ever, so the run is cut off at a hard limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycles, pending);
			$display("FAIL momentum_sgd_update");
			$finish;
		end
	end

	// The receiver idles at the current rate, except for one long hold-off once enough
	// results have come. The sender keeps offering items meanwhile, so the pipeline fills
	// and the block has to push back on its input.
	initial begin : receiver
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	// Offers one item, with random idle cycles in front of it, and returns at the falling
	// edge after it was taken. The valid line is only touched once per falling edge, so
	// back-to-back items keep it high.
	task automatic push_update(input elem_idx_t idx, input q16_t w, input q16_t g,
			input logic f);
		while ($urandom_range(0, 99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.elem_index <= idx;
		req_ch.weight_in  <= w;
		req_ch.grad_in    <= g;
		req_ch.fresh      <= f;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	// Register writes are only made while the block holds no item.
	task automatic write_reg(input cfg_idx_t idx, input coeff_t value);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata     <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// The sender stops and waits until every expected result has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// Mostly realistic magnitudes, with full-range words and the two extremes now and then.
	function automatic q16_t rand_value();
		case ($urandom_range(0, 9))
			0:       return q16_t'($urandom);
			1:       return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
			default: return q16_t'($urandom) >>> $urandom_range(6, 28);
		endcase
	endfunction

	// Optimiser passes over small tensors: the first pass over a tensor marks its elements
	// fresh, later passes build on the stored velocity. Single-element tensors put the same
	// index back to back. A draw is noise, one item with every field random, 15 times in 100. The
	// last tensor of a segment is cut short once the quota is reached.
	task automatic run_segment(input int quota);
		int done;
		int base;
		int len;
		int passes;
		done = 0;
		while (done < quota) begin
			if ($urandom_range(0, 99) < 15) begin
				push_update(elem_idx_t'($urandom), q16_t'($urandom), q16_t'($urandom),
					1'($urandom));
				done++;
			end else begin
				base   = $urandom_range(0, IDX_SPAN - 1);
				len    = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 24);
				passes = $urandom_range(1, 4);
				for (int p = 0; p < passes && done < quota; p++) begin
					for (int e = 0; e < len && done < quota; e++) begin
						push_update(elem_idx_t'(base + e), rand_value(), rand_value(), p == 0);
						done++;
					end
				end
			end
		end
	endtask

	initial begin : stimulus
		coeff_t mu;
		coeff_t lr;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.elem_index = '0;
		req_ch.weight_in = '0;
		req_ch.grad_in = '0;
		req_ch.fresh = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = REG_MOMENTUM;
		cfg_ch.wdata = '0;
		send_idle = 35;
		recv_idle = 54;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items with the coefficients left at their reset values. The first item
		// reads a velocity that only the clearing pass has written.
		push_update(12'd0, 32'sd0, 32'sd0, 1'b0);
		// Top index, extreme weight against extreme gradient: the weight saturates high,
		// then the same index again straight away saturates it low.
		push_update(12'd4095, Q_MAX, Q_MIN, 1'b0);
		push_update(12'd4095, Q_MIN, Q_MAX, 1'b0);
		push_update(12'd4095, 32'sd65536, 32'sd1234, 1'b1);
		// Velocity building up on one element over three steps.
		push_update(12'd17, 32'sd65536, 32'sd65536, 1'b1);
		push_update(12'd17, 32'sd65536, 32'sd65536, 1'b0);
		push_update(12'd17, 32'sd65536, 32'sd65536, 1'b0);
		push_update(12'd2048, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0);
		drain();
		settings++;

		// Writes past the register list, then both coefficients at their maximum.
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'hFFFF);
		write_reg(REG_MOMENTUM, 16'hFFFF);
		write_reg(REG_STEP_RATE, 16'hFFFF);
		// A steep gradient twice in a row drives the velocity itself into saturation,
		// once upwards and once downwards.
		push_update(12'd100, 32'sd0, Q_MIN, 1'b1);
		push_update(12'd100, 32'sd0, Q_MIN, 1'b0);
		push_update(12'd200, 32'sd0, Q_MAX, 1'b1);
		push_update(12'd200, Q_MIN, Q_MAX, 1'b0);
		// Exact halves in the rounding, one on each side of zero.
		push_update(12'd300, 32'sd0, 32'sd32768, 1'b1);
		push_update(12'd301, 32'sd0, -32'sd32768, 1'b1);
		push_update(12'd302, 32'sd1, 32'sd1, 1'b1);
		drain();
		settings++;

		// Both coefficients zero: the saturated velocity and the gradient drop out.
		write_reg(REG_MOMENTUM, 16'd0);
		write_reg(REG_STEP_RATE, 16'd0);
		push_update(12'd100, 32'sd12345, Q_MAX, 1'b0);
		push_update(12'd4095, Q_MAX, Q_MIN, 1'b0);
		drain();
		settings++;

		// Random part: the idling rates swap after two segments and stop after four, and
		// every segment runs under a coefficient setting of its own.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == 2) begin
				send_idle = 54;
				recv_idle = 35;
			end
			if (seg == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			case (seg)
				0: begin
					mu = 16'hFFFF;
					lr = coeff_t'($urandom);
				end
				1: begin
					mu = 16'd0;
					lr = 16'hFFFF;
				end
				3: begin
					mu = coeff_t'($urandom);
					lr = 16'd0;
				end
				default: begin
					mu = coeff_t'($urandom);
					lr = coeff_t'($urandom);
				end
			endcase
			write_reg(REG_MOMENTUM, mu);
			write_reg(REG_STEP_RATE, lr);
			run_segment(RANDOM_ITEMS / SEGMENTS);
			drain();
			settings++;
		end

		// Any stray result would show up during the settling wait.
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Sent %0d updates and checked %0d results, %0d of them saturated.",
			items_sent, results_seen, clip_count);
		$display("Ran %0d coefficient settings, idling both ways and with one long stall.",
			settings);
		if (mismatches == 0 && pending == 0)
			$display("PASS momentum_sgd_update");
		else
			$display("FAIL momentum_sgd_update");
		$finish;
	end

endmodule

// ===== momentum_sgd_update.f =====
sv/msgd_pkg.sv
sv/msgd_intf.sv
sv/momentum_sgd_update.sv
verif/momentum_sgd_update_check.sv
verif/momentum_sgd_update_test.sv
